// ===== src/roman_numeral_encoder_macros.svh =====
// ============================================================================
// roman numeral encoder assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ============================================================================
`ifndef ROMAN_NUMERAL_ENCODER_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_MACROS_SVH

// same-cycle implication
`define RNE_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RNE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/rne_pkg.sv =====
// ============================================================================
// rne_pkg
// types, constants and value tables of the roman numeral encoder
// ============================================================================
`default_nettype none

package rne_pkg;

    localparam int VALUE_W     = 12;
    localparam int SYM_W       = 7;
    localparam int STEP_W      = 4;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [VALUE_W-1:0] MAX_VALID = 12'd3999;

    localparam logic [SYM_W-1:0] CH_NONE = 7'd0;
    localparam logic [SYM_W-1:0] CH_ERR  = 7'd45;
    localparam logic [SYM_W-1:0] CH_C    = 7'd67;
    localparam logic [SYM_W-1:0] CH_D    = 7'd68;
    localparam logic [SYM_W-1:0] CH_I    = 7'd73;
    localparam logic [SYM_W-1:0] CH_L    = 7'd76;
    localparam logic [SYM_W-1:0] CH_M    = 7'd77;
    localparam logic [SYM_W-1:0] CH_V    = 7'd86;
    localparam logic [SYM_W-1:0] CH_X    = 7'd88;

    // classified item handed from front to back
    typedef struct packed {
        logic               err;
        logic [VALUE_W-1:0] value;
    } rne_item_t;

    function automatic logic [VALUE_W-1:0] step_value(input logic [STEP_W-1:0] idx);
        logic [VALUE_W-1:0] v;
        unique case (idx)
            4'd0:    v = 12'd1000;
            4'd1:    v = 12'd900;
            4'd2:    v = 12'd500;
            4'd3:    v = 12'd400;
            4'd4:    v = 12'd100;
            4'd5:    v = 12'd90;
            4'd6:    v = 12'd50;
            4'd7:    v = 12'd40;
            4'd8:    v = 12'd10;
            4'd9:    v = 12'd9;
            4'd10:   v = 12'd5;
            4'd11:   v = 12'd4;
            default: v = 12'd1;
        endcase
        return v;
    endfunction

    function automatic logic [SYM_W-1:0] first_char(input logic [STEP_W-1:0] idx);
        logic [SYM_W-1:0] c;
        unique case (idx)
            4'd0:    c = CH_M;
            4'd1:    c = CH_C;
            4'd2:    c = CH_D;
            4'd3:    c = CH_C;
            4'd4:    c = CH_C;
            4'd5:    c = CH_X;
            4'd6:    c = CH_L;
            4'd7:    c = CH_X;
            4'd8:    c = CH_X;
            4'd9:    c = CH_I;
            4'd10:   c = CH_V;
            default: c = CH_I;
        endcase
        return c;
    endfunction

    // CH_NONE marks a single-character entry
    function automatic logic [SYM_W-1:0] second_char(input logic [STEP_W-1:0] idx);
        logic [SYM_W-1:0] c;
        unique case (idx)
            4'd1:    c = CH_M;
            4'd3:    c = CH_D;
            4'd5:    c = CH_C;
            4'd7:    c = CH_L;
            4'd9:    c = CH_X;
            4'd11:   c = CH_V;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== src/rne_front.sv =====
// ============================================================================
// rne_front
// input stage: takes an item, range-checks it and pushes it to the queue
// ============================================================================
`default_nettype none

module rne_front
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [rne_pkg::VALUE_W-1:0]   value,
    input  wire logic                          q_full,
    output logic                               q_push,
    output rne_pkg::rne_item_t                 q_item
);
    import rne_pkg::*;

    logic      front_valid_reg;
    logic      front_valid_next;
    rne_item_t front_item_reg;
    rne_item_t front_item_next;
    logic      accept;

    assign q_push        = front_valid_reg && !q_full;
    assign s_axis_tready = !front_valid_reg || q_push;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign q_item        = front_item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_item_next  = front_item_reg;
        if (accept)
        begin
            front_valid_next      = 1'b1;
            front_item_next.value = value;
            front_item_next.err   = (value == '0) || (value > MAX_VALID);
        end
        else if (q_push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

endmodule

`default_nettype wire

// ===== src/rne_queue.sv =====
// ============================================================================
// rne_queue
// short fifo of classified items between front and back
// ============================================================================
`default_nettype none
`include "roman_numeral_encoder_macros.svh"

module rne_queue
#(
    parameter int DEPTH = rne_pkg::QUEUE_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire rne_pkg::rne_item_t  push_item,
    input  wire logic                pop,
    output rne_pkg::rne_item_t       head,
    output logic                     full,
    output logic                     empty
);
    import rne_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    rne_item_t        slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full  = (count_reg == DEPTH_CNT);
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    `RNE_ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= DEPTH_CNT, "queue count over depth")
    `RNE_ASSERT_IMPLY(a_no_overflow, push, !full || pop, "push into full queue")
    `RNE_ASSERT_NEXT(a_push_fills, push && !pop, !empty, "queue empty after push")

endmodule

`default_nettype wire

// ===== src/rne_back.sv =====
// ============================================================================
// rne_back
// greedy numeral sequencer, registered output, takes a value only when idle
// ============================================================================
`default_nettype none
`include "roman_numeral_encoder_macros.svh"

module rne_back
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire rne_pkg::rne_item_t          q_head,
    input  wire logic                        q_empty,
    output logic                             q_pop,
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic [rne_pkg::SYM_W-1:0]        symbol,
    output logic                             m_axis_tlast,
    output logic                             out_of_range
);
    import rne_pkg::*;

    logic               busy_reg,      busy_next;
    logic               err_reg,       err_next;
    logic [VALUE_W-1:0] remaining_reg, remaining_next;
    logic [STEP_W-1:0]  step_reg,      step_next;
    logic               pending_reg,   pending_next;
    logic               out_valid_reg, out_valid_next;
    logic [SYM_W-1:0]   symbol_reg,    symbol_next;
    logic               last_reg,      last_next;
    logic               oor_reg,       oor_next;

    logic [VALUE_W-1:0] sv;
    logic [VALUE_W-1:0] diff;
    logic [SYM_W-1:0]   fc;
    logic [SYM_W-1:0]   sc;
    logic               slot_free;

    assign sv        = step_value(step_reg);
    assign fc        = first_char(step_reg);
    assign sc        = second_char(step_reg);
    assign diff      = remaining_reg - sv;
    assign slot_free = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        busy_next      = busy_reg;
        err_next       = err_reg;
        remaining_next = remaining_reg;
        step_next      = step_reg;
        pending_next   = pending_reg;
        out_valid_next = out_valid_reg;
        symbol_next    = symbol_reg;
        last_next      = last_reg;
        oor_next       = oor_reg;
        q_pop          = 1'b0;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (!busy_reg)
        begin
            if (!q_empty)
            begin
                q_pop          = 1'b1;
                busy_next      = 1'b1;
                err_next       = q_head.err;
                remaining_next = q_head.value;
                step_next      = '0;
                pending_next   = 1'b0;
            end
        end
        else if (slot_free)
        begin
            priority if (err_reg)
            begin
                out_valid_next = 1'b1;
                symbol_next    = CH_ERR;
                last_next      = 1'b1;
                oor_next       = 1'b1;
                busy_next      = 1'b0;
                remaining_next = '0;
            end
            else if (pending_reg)
            begin
                out_valid_next = 1'b1;
                symbol_next    = sc;
                last_next      = (remaining_reg == '0);
                oor_next       = 1'b0;
                pending_next   = 1'b0;
                busy_next      = (remaining_reg != '0);
            end
            else if (remaining_reg >= sv)
            begin
                out_valid_next = 1'b1;
                symbol_next    = fc;
                last_next      = (diff == '0) && (sc == CH_NONE);
                oor_next       = 1'b0;
                remaining_next = diff;
                pending_next   = (sc != CH_NONE);
                busy_next      = !((diff == '0) && (sc == CH_NONE));
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            err_reg       <= 1'b0;
            remaining_reg <= '0;
            step_reg      <= '0;
            pending_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            err_reg       <= err_next;
            remaining_reg <= remaining_next;
            step_reg      <= step_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        symbol_reg <= symbol_next;
        last_reg   <= last_next;
        oor_reg    <= oor_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign symbol        = symbol_reg;
    assign m_axis_tlast  = last_reg;
    assign out_of_range  = oor_reg;

    `RNE_ASSERT_IMPLY(a_err_is_last, out_valid_reg && oor_reg, last_reg, "error item not last")
    `RNE_ASSERT_IMPLY(a_err_symbol, out_valid_reg && oor_reg, symbol_reg == CH_ERR,
        "error item with wrong symbol")
    `RNE_ASSERT_IMPLY(a_remaining_range, busy_reg && !err_reg, remaining_reg <= MAX_VALID,
        "remaining value out of range")

endmodule

`default_nettype wire

// ===== src/roman_numeral_encoder.sv =====
// ============================================================================
// roman_numeral_encoder
// integer to roman numeral converter, one ascii character per output item
// ============================================================================
// path: an accepted value is registered in the input stage, then in a queue
//   slot, then in the sequencer, which steps past table entries until the first
//   match and loads the first character into the output register; the greedy
//   sequencer takes a new value only once the last is done, the queue holds more
// reset: rst_n is asynchronous active low, it empties the input stage and the
//   queue and idles the sequencer; no output item is pending after reset
`default_nettype none

module roman_numeral_encoder
#(
    parameter int QUEUE_DEPTH = rne_pkg::QUEUE_DEPTH
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // input item stream
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  wire logic [rne_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // [11:0] value, rest zero
    // output character stream
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    output logic [rne_pkg::M_TDATA_W-1:0]          m_axis_tdata,  // [6:0] symbol, [7] zero
    output logic                                   m_axis_tlast,  // last character of numeral
    output logic                                   m_axis_tuser   // [0] out_of_range
);
    import rne_pkg::*;

    // front to queue
    logic      q_push;
    rne_item_t q_item;
    logic      q_full;
    // queue to back
    logic      q_pop;
    rne_item_t q_head;
    logic      q_empty;
    // back outputs
    logic [SYM_W-1:0] symbol;
    logic             out_of_range;

    // front: accepts the value and flags 0 or above 3999 as an error
    rne_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .value         (s_axis_tdata[VALUE_W-1:0]),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_item        (q_item)
    );

    // queue decouples input acceptance from the character run
    rne_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    // back: walks the value table greedily, one character or one table
    // step per cycle while the output is not stalled, into a registered output stage
    rne_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .symbol        (symbol),
        .m_axis_tlast  (m_axis_tlast),
        .out_of_range  (out_of_range)
    );

    // pack symbol into the low bits, pad to a whole byte
    assign m_axis_tdata = {{(M_TDATA_W-SYM_W){1'b0}}, symbol};
    assign m_axis_tuser = out_of_range;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// drives integers into the roman numeral encoder and checks every output
// character against a typed-in numeral or a greedy conversion done in the
// bench, under several sender idle and receiver stall mixes, one long
// receiver hold-off and one full drain pause
// ============================================================================

module tb;

    import rne_pkg::*;

    localparam int        CLK_HALF    = 5;
    localparam int        RESET_LEN   = 12;
    localparam int        DIRECTED_N  = 23;
    localparam int        PHASE_ITEMS = 22;
    localparam int        LONG_HOLD   = 300;
    localparam int        TAIL_CYCLES = 64;
    localparam int        QUIET_LIMIT = 4000;
    localparam int        PLACES      = 13;

    // one output character as the encoder should deliver it
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             out_of_range;
    } glyph_t;

    // greedy table of the bench, largest place first
    localparam int unsigned PLACE_VALUE [PLACES] =
        '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
    localparam logic [SYM_W-1:0] PLACE_LEAD [PLACES] =
        '{CH_M, CH_C, CH_D, CH_C, CH_C, CH_X, CH_L, CH_X, CH_X, CH_I, CH_V, CH_I, CH_I};
    localparam logic [SYM_W-1:0] PLACE_TAIL [PLACES] =
        '{CH_NONE, CH_M, CH_NONE, CH_D, CH_NONE, CH_C, CH_NONE, CH_L,
          CH_NONE, CH_X, CH_NONE, CH_V, CH_NONE};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    glyph_t      pending_glyphs [$];
    int unsigned mismatch_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_asks = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    int unsigned quiet_cycles = 0;

    // directed values; a numeral is typed in where it reads off at a glance,
    // an empty one leaves the row to the bench's own conversion
    logic [VALUE_W-1:0] value_tab [DIRECTED_N] = '{
        12'd0, 12'd4095, 12'd4000, 12'd3999, 12'd1, 12'd3888, 12'd4, 12'd9,
        12'd40, 12'd90, 12'd400, 12'd900, 12'd1000, 12'd3, 12'd5, 12'd50,
        12'd500, 12'd2048, 12'd2730, 12'd1365, 12'd1994, 12'd3998, 12'd2222
    };
    string numeral_tab [DIRECTED_N] = '{
        "-", "-", "-", "MMMCMXCIX", "I", "MMMDCCCLXXXVIII", "IV", "IX",
        "XL", "XC", "CD", "CM", "M", "III", "V", "L",
        "D", "", "", "", "", "", ""
    };

    roman_numeral_encoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [11:0] value, rest zero
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [6:0] symbol, [7] zero
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)    // [0] out_of_range
    );

    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // greedy conversion of one value into the characters it should produce
    function automatic void queue_numeral(input logic [VALUE_W-1:0] v);
        logic [SYM_W-1:0] chars [$];
        int unsigned      left;
        int unsigned      p;
        glyph_t           g;
        if (v == '0 || v > MAX_VALID)
        begin
            g = '{symbol: CH_ERR, last: 1'b1, out_of_range: 1'b1};
            pending_glyphs.push_back(g);
            return;
        end
        left = v;
        for (p = 0; p < PLACES; p++)
        begin
            while (left >= PLACE_VALUE[p])
            begin
                left -= PLACE_VALUE[p];
                chars.push_back(PLACE_LEAD[p]);
                if (PLACE_TAIL[p] != CH_NONE)
                    chars.push_back(PLACE_TAIL[p]);
            end
        end
        foreach (chars[i])
        begin
            g = '{symbol: chars[i], last: (i == chars.size() - 1), out_of_range: 1'b0};
            pending_glyphs.push_back(g);
        end
    endfunction

    // typed-in numeral; a lone dash stands for the out-of-range marker
    function automatic void queue_typed(input string numeral);
        glyph_t g;
        int     i;
        for (i = 0; i < numeral.len(); i++)
        begin
            g.symbol       = SYM_W'(numeral[i]);
            g.last         = (i == numeral.len() - 1);
            g.out_of_range = (numeral == "-");
            pending_glyphs.push_back(g);
        end
    endfunction

    // offers one value and returns at the edge where it is taken;
    // tvalid stays high afterwards unless an idle gap or a drain wait follows
    task automatic send_value(input logic [VALUE_W-1:0] v, input string numeral);
        if ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < sender_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(S_TDATA_W - VALUE_W){1'b0}}, v};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (numeral.len() != 0)
            queue_typed(numeral);
        else
            queue_numeral(v);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_glyphs.size() != 0)
            @(posedge clk);
    endtask

    // mostly valid values built digit by digit, some small, some out of range
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1) ? '0 : VALUE_W'($urandom_range(4000, 4095));
            1, 2:    v = VALUE_W'($urandom_range(1, 60));
            3:       v = VALUE_W'($urandom_range(1, 3999));
            default: v = VALUE_W'($urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                                  + $urandom_range(0, 9) * 10 + $urandom_range(0, 9));
        endcase
        return v;
    endfunction

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_seen     <= hold_asks;
            hold_left     <= LONG_HOLD;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // output checker: each accepted character against the oldest expectation
    always @(posedge clk)
    begin
        glyph_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_glyphs.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual symbol %0d last %0b oor %0b",
                         $time, m_axis_tdata[SYM_W-1:0], m_axis_tlast, m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = pending_glyphs.pop_front();
                if (m_axis_tdata[SYM_W-1:0] != want.symbol)
                begin
                    $display("%0t: symbol mismatch, expected %0d actual %0d",
                             $time, want.symbol, m_axis_tdata[SYM_W-1:0]);
                    mismatch_count++;
                end
                if (m_axis_tlast != want.last)
                begin
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $time, want.last, m_axis_tlast);
                    mismatch_count++;
                end
                if (m_axis_tuser != want.out_of_range)
                begin
                    $display("%0t: out_of_range mismatch, expected %0b actual %0b",
                             $time, want.out_of_range, m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog on stretches where neither side moves an item
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int phase;
        int n;
        repeat (RESET_LEN)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (n = 0; n < DIRECTED_N; n++)
            send_value(value_tab[n], numeral_tab[n]);

        // phases: no idling, sender idle, receiver stall, both
        for (phase = 0; phase < 4; phase++)
        begin
            sender_idle_pct = (phase == 1) ? 64 : (phase == 3) ? 31 : 0;
            recv_stall_pct <= (phase == 2) ? 64 : (phase == 3) ? 31 : 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // receiver holds off while values keep coming, so input backs up
                if (phase == 0 && n == 4)
                    hold_asks <= hold_asks + 1;
                // sender pauses until everything is out
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_drained();
                send_value(pick_value(), "");
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
